/* rtl/core/tds_pkg.sv */
`timescale 1ns / 1ps

package tds_pkg;

  // Table size and derived widths
  localparam int MaxTasks  = 32;
  localparam int IdxW      = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW      = $clog2(MaxTasks + 1);
  localparam int IdW       = 6;
  localparam int CmpW      = IdW + 1;
  localparam int ReadyW    = 32;
  localparam int ReadyIdxW = 5;

  // Commands
  typedef enum logic [2:0] {
    CmdClear   = 3'd0,
    CmdAddTask = 3'd1,
    CmdAddDep  = 3'd2,
    CmdStart   = 3'd3,
    CmdFinish  = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatUnknown = 2'd1,
    StatFull    = 2'd2
  } stat_e;

  // Per-task status
  typedef enum logic [1:0] {
    TsPending   = 2'd0,
    TsRunning   = 2'd1,
    TsCompleted = 2'd2,
    TsFailed    = 2'd3
  } task_st_e;

  // Sequencer states
  typedef enum logic [2:0] {
    SIdle,
    SExec,
    SModify,
    SScan,
    SDrain,
    SDone
  } seq_st_e;

  // Input item
  typedef struct packed {
    logic [2:0]     cmd;
    logic [IdW-1:0] task_id;
    logic [IdW-1:0] dependent_id;
    logic           task_failed;
  } cmd_req_t;

  // Result item
  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    new_task_id;
    logic [ReadyW-1:0] ready_mask;
    logic              all_done;
    logic              any_failed;
  } cmd_rsp_t;

endpackage

/* rtl/core/task_dependency_scoreboard_unit.sv */
`timescale 1ns / 1ps

// Task dependency scoreboard: holds up to MaxTasks tasks, each with a status and a row of
// prerequisite bits kept in a single-port-read memory. Every accepted command yields one
// result item. From acceptance to result a command passes through the execute state, the
// modify state for a valid add dependency (which reads, modifies and writes back a
// prerequisite row), the scan, with one memory read per row while a single comparator
// walks the table to build the ready mask and the summary flags, the drain state and the
// completion state, which loads the output register. The next command is taken while the
// previous result waits in that register, from the cycle after it is loaded, and not before.
// A result still waiting when the next one is ready holds the sequencer.
module task_dependency_scoreboard_unit
  import tds_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cmd_req_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cmd_rsp_t out_item_o
);

  // Sequencer and command state
  seq_st_e           state_q, state_d;
  cmd_req_t          req_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              eval_vld_q;
  logic [IdxW-1:0]   eval_idx_q;

  // Result accumulators and output register
  logic [1:0]        res_stat_q, res_stat_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic [ReadyW-1:0] res_ready_q, res_ready_d;
  logic              res_done_q, res_done_d;
  logic              res_fail_q, res_fail_d;
  logic              out_valid_q, out_valid_d;
  cmd_rsp_t          out_q, out_d;

  // Task status registers
  task_st_e          status_q [MaxTasks];
  logic              st_we;
  logic [IdxW-1:0]   st_waddr;
  task_st_e          st_wdata;

  // Prerequisite row memory
  logic [MaxTasks-1:0] rows_mem [MaxTasks];
  logic [MaxTasks-1:0] row_rd_q;
  logic                row_we;
  logic [IdxW-1:0]     row_waddr;
  logic [MaxTasks-1:0] row_wdata;
  logic [IdxW-1:0]     row_raddr;

  logic [MaxTasks-1:0] done_mask;
  logic [IdW-1:0]      tid_m1, did_m1;
  logic                tid_ok, did_ok;
  logic                eval_in_range;
  task_st_e            eval_st;
  logic [ReadyIdxW-1:0] ready_idx;

  function automatic logic id_known(input logic [IdW-1:0] id, input logic [CntW-1:0] cnt);
    return (id != '0) && (CmpW'(id) <= CmpW'(cnt));
  endfunction

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign tid_m1 = req_q.task_id - IdW'(1);
  assign did_m1 = req_q.dependent_id - IdW'(1);
  assign tid_ok = id_known(req_q.task_id, count_q);
  assign did_ok = id_known(req_q.dependent_id, count_q);

  // Completed tasks among those that exist
  always_comb begin
    for (int i = 0; i < MaxTasks; i++) begin
      done_mask[i] = (CmpW'(i) < CmpW'(count_q)) && (status_q[i] == TsCompleted);
    end
  end

  assign eval_in_range = CmpW'(eval_idx_q) < CmpW'(count_q);
  assign eval_st       = status_q[eval_idx_q];
  assign ready_idx     = ReadyIdxW'(eval_idx_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) state_d = SExec;
      end
      SExec: begin
        if ((cmd_e'(req_q.cmd) == CmdAddDep) && tid_ok && did_ok) state_d = SModify;
        else state_d = SScan;
      end
      SModify: state_d = SScan;
      SScan: begin
        if (scan_q == IdxW'(MaxTasks - 1)) state_d = SDrain;
      end
      SDrain: state_d = SDone;
      SDone: begin
        if (!out_valid_q || out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Datapath control
  always_comb begin
    count_d     = count_q;
    scan_d      = scan_q;
    res_stat_d  = res_stat_q;
    res_id_d    = res_id_q;
    res_ready_d = res_ready_q;
    res_done_d  = res_done_q;
    res_fail_d  = res_fail_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    st_we       = 1'b0;
    st_waddr    = tid_m1[IdxW-1:0];
    st_wdata    = TsRunning;
    row_we      = 1'b0;
    row_waddr   = did_m1[IdxW-1:0];
    row_wdata   = row_rd_q | (MaxTasks'(1) << tid_m1[IdxW-1:0]);
    row_raddr   = scan_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      SExec: begin
        res_stat_d  = StatOk;
        res_id_d    = '0;
        res_ready_d = '0;
        res_done_d  = 1'b1;
        res_fail_d  = 1'b0;
        scan_d      = '0;
        row_raddr   = did_m1[IdxW-1:0];
        case (cmd_e'(req_q.cmd))
          CmdClear: count_d = '0;
          CmdAddTask: begin
            if (count_q == CntW'(MaxTasks)) begin
              res_stat_d = StatFull;
            end else begin
              st_we     = 1'b1;
              st_waddr  = IdxW'(count_q);
              st_wdata  = TsPending;
              row_we    = 1'b1;
              row_waddr = IdxW'(count_q);
              row_wdata = '0;
              count_d   = count_q + CntW'(1);
              res_id_d  = IdW'(count_q) + IdW'(1);
            end
          end
          CmdAddDep: begin
            if (!tid_ok || !did_ok) res_stat_d = StatUnknown;
          end
          CmdStart: begin
            if (!tid_ok) begin
              res_stat_d = StatUnknown;
            end else begin
              st_we    = 1'b1;
              st_wdata = TsRunning;
            end
          end
          CmdFinish: begin
            if (!tid_ok) begin
              res_stat_d = StatUnknown;
            end else begin
              st_we    = 1'b1;
              st_wdata = req_q.task_failed ? TsFailed : TsCompleted;
            end
          end
          default: ;
        endcase
      end
      // write back the row with the new prerequisite bit
      SModify: row_we = 1'b1;
      SScan: scan_d = scan_q + IdxW'(1);
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = res_stat_q;
          out_d.new_task_id = res_id_q;
          out_d.ready_mask  = res_ready_q;
          out_d.all_done    = res_done_q;
          out_d.any_failed  = res_fail_q;
        end
      end
      default: ;
    endcase

    // one table entry checked per cycle, in the cycle after its row read
    if (eval_vld_q && eval_in_range) begin
      if (eval_st == TsFailed) res_fail_d = 1'b1;
      if (eval_st != TsCompleted && eval_st != TsFailed) res_done_d = 1'b0;
      if (eval_st == TsPending && ((row_rd_q & ~done_mask) == '0) &&
          (int'(eval_idx_q) < ReadyW)) begin
        res_ready_d[ready_idx] = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      scan_q      <= '0;
      eval_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      eval_vld_q  <= (state_q == SScan);
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_item_i;
    eval_idx_q  <= scan_q;
    res_stat_q  <= res_stat_d;
    res_id_q    <= res_id_d;
    res_ready_q <= res_ready_d;
    res_done_q  <= res_done_d;
    res_fail_q  <= res_fail_d;
    out_q       <= out_d;
  end

  // Status table
  always_ff @(posedge clk_i) begin
    if (st_we) status_q[st_waddr] <= st_wdata;
  end

  // Prerequisite memory
  always_ff @(posedge clk_i) begin
    if (row_we) rows_mem[row_waddr] <= row_wdata;
    row_rd_q <= rows_mem[row_raddr];
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(MaxTasks))
    else $error("task count beyond table size");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == SExec))
    else $error("accepted item not executed");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SExec) |=> (state_q == SModify || (state_q == SScan && scan_q == '0)))
    else $error("scan did not start at first row");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == SDone))
    else $error("result loaded outside completion");

endmodule

/* sim/tb_task_dependency_scoreboard_unit.sv */
`timescale 1ns / 1ps

module tb_task_dependency_scoreboard_unit;
  import tds_pkg::*;

  // Commands the block ignores
  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareHi = 3'd7;

  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned TailCycles   = MaxTasks + 8;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  cmd_req_t in_item   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cmd_rsp_t out_item;

  // Commands waiting to be offered, results waiting to come back
  cmd_req_t    cmd_q[$];
  cmd_rsp_t    awaited_rsp_q[$];

  int unsigned tx_idle_pct  = 24;
  int unsigned rx_idle_pct  = 48;
  bit          hold_request = 1'b0;
  int unsigned fail_count   = 0;

  // Shadow task table, advanced on every accepted command
  int unsigned       tbl_count = 0;
  task_st_e          tbl_state  [MaxTasks];
  logic [MaxTasks-1:0] tbl_prereq [MaxTasks];

  // Stimulus-side view of the table size
  int unsigned gen_count = 0;
  int unsigned issued    = 0;

  always #5 clk = ~clk;

  task_dependency_scoreboard_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // Apply one command to the shadow table and work out its result item
  function automatic cmd_rsp_t apply_task_cmd(cmd_req_t req);
    cmd_rsp_t            rsp;
    logic [MaxTasks-1:0] completed;
    logic                tid_ok;
    logic                did_ok;
    int unsigned         tid;
    int unsigned         did;
    tid       = req.task_id;
    did       = req.dependent_id;
    tid_ok    = (tid >= 1) && (tid <= tbl_count);
    did_ok    = (did >= 1) && (did <= tbl_count);
    rsp       = '0;
    completed = '0;
    rsp.all_done = 1'b1;
    case (req.cmd)
      CmdClear: begin
        tbl_count = 0;
      end
      CmdAddTask: begin
        if (tbl_count >= MaxTasks) begin
          rsp.status = StatFull;
        end else begin
          tbl_state[tbl_count]  = TsPending;
          tbl_prereq[tbl_count] = '0;
          tbl_count++;
          rsp.new_task_id = IdW'(tbl_count);
        end
      end
      CmdAddDep: begin
        if (!tid_ok || !did_ok) rsp.status = StatUnknown;
        else tbl_prereq[did-1][tid-1] = 1'b1;
      end
      CmdStart: begin
        if (!tid_ok) rsp.status = StatUnknown;
        else tbl_state[tid-1] = TsRunning;
      end
      CmdFinish: begin
        if (!tid_ok) rsp.status = StatUnknown;
        else tbl_state[tid-1] = req.task_failed ? TsFailed : TsCompleted;
      end
      default: ;
    endcase
    // summary flags and completed set
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_state[i] == TsCompleted) completed[i] = 1'b1;
      if (tbl_state[i] == TsFailed) rsp.any_failed = 1'b1;
      if (tbl_state[i] != TsCompleted && tbl_state[i] != TsFailed) rsp.all_done = 1'b0;
    end
    // pending tasks with every prerequisite completed
    for (int i = 0; i < tbl_count && i < ReadyW; i++) begin
      if (tbl_state[i] == TsPending && (tbl_prereq[i] & ~completed) == '0)
        rsp.ready_mask[i] = 1'b1;
    end
    return rsp;
  endfunction

  function automatic void queue_cmd(logic [2:0] cmd, logic [IdW-1:0] tid,
                                    logic [IdW-1:0] did, logic failed);
    cmd_req_t req;
    req.cmd          = cmd;
    req.task_id      = tid;
    req.dependent_id = did;
    req.task_failed  = failed;
    cmd_q = {cmd_q, req};
    if (cmd == CmdClear) gen_count = 0;
    if (cmd == CmdAddTask && gen_count < MaxTasks) gen_count++;
    if (cmd <= CmdFinish) issued++;
  endfunction

  function automatic logic [IdW-1:0] pick_task();
    return (gen_count == 0) ? '0 : IdW'($urandom_range(1, gen_count));
  endfunction

  // One well-formed round: clear, build a table, then wire and run it
  task automatic play_round(int unsigned size);
    int unsigned    r;
    logic [IdW-1:0] a;
    logic [IdW-1:0] b;
    queue_cmd(CmdClear, IdW'($urandom), IdW'($urandom), 1'($urandom));
    repeat (size) queue_cmd(CmdAddTask, IdW'($urandom), IdW'($urandom), 1'($urandom));
    repeat (size * 4) begin
      r = $urandom_range(99);
      a = pick_task();
      b = pick_task();
      if (r < 30) begin
        // mostly lower id as prerequisite so that cycles in the graph stay rare
        if (a > b && $urandom_range(3) != 0) queue_cmd(CmdAddDep, b, a, 1'b0);
        else queue_cmd(CmdAddDep, a, b, 1'($urandom));
      end else if (r < 50) begin
        queue_cmd(CmdStart, a, IdW'($urandom), 1'($urandom));
      end else if (r < 80) begin
        queue_cmd(CmdFinish, a, IdW'($urandom), ($urandom_range(9) == 0));
      end else if (r < 86) begin
        queue_cmd(CmdAddTask, IdW'($urandom), IdW'($urandom), 1'($urandom));
      end else if (r < 96) begin
        // noise: any id at all
        queue_cmd(3'($urandom_range(CmdAddDep, CmdFinish)), IdW'($urandom),
                  IdW'($urandom), 1'($urandom));
      end else begin
        queue_cmd(3'($urandom_range(CmdSpareLo, CmdSpareHi)), IdW'($urandom),
                  IdW'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic add_random(int unsigned count);
    int unsigned target;
    target = issued + count;
    while (issued < target)
      play_round(($urandom_range(7) == 0) ? MaxTasks : $urandom_range(1, 10));
  endtask

  // checked between edges, once every assignment of the edge has settled
  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_valid || awaited_rsp_q.size() != 0) @(negedge clk);
  endtask

  // Command driver
  always @(posedge clk) begin
    logic free;
    free = !in_valid;
    if (in_valid && in_ready) begin
      awaited_rsp_q = {awaited_rsp_q, apply_task_cmd(in_item)};
      free = 1'b1;
    end
    if (free) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_item  <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure
  int unsigned hold_cycles = 0;
  bit          hold_done   = 1'b0;

  always @(posedge clk) begin
    cmd_rsp_t exp_rsp;
    if (out_valid && out_ready) begin
      if (awaited_rsp_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        exp_rsp = awaited_rsp_q.pop_front();
        if (out_item.status !== exp_rsp.status) begin
          $error("status: expected %0d got %0d", exp_rsp.status, out_item.status);
          fail_count++;
        end
        if (out_item.new_task_id !== exp_rsp.new_task_id) begin
          $error("new_task_id: expected %0d got %0d", exp_rsp.new_task_id,
                 out_item.new_task_id);
          fail_count++;
        end
        if (out_item.ready_mask !== exp_rsp.ready_mask) begin
          $error("ready_mask: expected %h got %h", exp_rsp.ready_mask, out_item.ready_mask);
          fail_count++;
        end
        if (out_item.all_done !== exp_rsp.all_done) begin
          $error("all_done: expected %0b got %0b", exp_rsp.all_done, out_item.all_done);
          fail_count++;
        end
        if (out_item.any_failed !== exp_rsp.any_failed) begin
          $error("any_failed: expected %0b got %0b", exp_rsp.any_failed,
                 out_item.any_failed);
          fail_count++;
        end
      end
    end
    if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= RxHoldCycles) hold_done = 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, ids at both ends, self dependency, repeats, spares
    queue_cmd(CmdStart, 1, 0, 1'b0);
    queue_cmd(CmdSpareHi, 63, 63, 1'b1);
    queue_cmd(CmdAddTask, 0, 0, 1'b0);
    queue_cmd(CmdAddTask, 63, 63, 1'b1);
    queue_cmd(CmdAddTask, 0, 0, 1'b0);
    queue_cmd(CmdAddDep, 1, 2, 1'b0);
    queue_cmd(CmdAddDep, 2, 3, 1'b0);
    queue_cmd(CmdAddDep, 3, 3, 1'b0);
    queue_cmd(CmdAddDep, 0, 2, 1'b0);
    queue_cmd(CmdAddDep, 1, 4, 1'b0);
    queue_cmd(CmdAddDep, 32, 32, 1'b1);
    queue_cmd(CmdFinish, 63, 0, 1'b1);
    queue_cmd(CmdStart, 1, 0, 1'b0);
    queue_cmd(CmdFinish, 1, 0, 1'b0);
    queue_cmd(CmdFinish, 2, 0, 1'b1);
    queue_cmd(CmdStart, 2, 0, 1'b0);
    queue_cmd(CmdFinish, 2, 0, 1'b0);
    queue_cmd(CmdFinish, 3, 0, 1'b1);
    queue_cmd(CmdFinish, 3, 0, 1'b0);
    queue_cmd(CmdSpareLo, 0, 0, 1'b0);
    queue_cmd(CmdClear, 63, 63, 1'b1);
    queue_cmd(CmdFinish, 1, 0, 1'b0);

    // full table first, then mixed rounds
    play_round(MaxTasks);
    add_random(150);
    wait_drained();

    tx_idle_pct = 48;
    rx_idle_pct = 24;
    add_random(300);
    wait_drained();

    // no idling; receiver holds off long enough to back up the input
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    add_random(130);
    wait_drained();
    add_random(150);
    wait_drained();

    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && awaited_rsp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
